// ===== rtl/complex_rect_to_polar_top_macros.svh =====
// ----------------------------------------------------------------------------
// complex_rect_to_polar_top_macros.svh
// Assertion macros shared by the rectangular-to-polar converter modules.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_RECT_TO_POLAR_TOP_MACROS_SVH
`define COMPLEX_RECT_TO_POLAR_TOP_MACROS_SVH

// same-cycle implication
`define CRP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg
// Constants of the rectangular-to-polar converter: angle format, CORDIC
// arctangent table and fixed turn values.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int ANGLE_WIDTH   = 32;
  localparam int CORDIC_STEPS  = 31;
  localparam int PRESCALE      = 16;
  localparam int GUARD_BITS    = 3;
  localparam int PHASE_LATENCY = CORDIC_STEPS + 2;

  localparam logic [ANGLE_WIDTH-1:0] ZERO_TURN          = 32'h0000_0000;
  localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN       = 32'h4000_0000;
  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN          = 32'h8000_0000;
  localparam logic [ANGLE_WIDTH-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ANGLE_WIDTH-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1
  };

endpackage

// ===== rtl/crp_bin_if.sv =====
// ----------------------------------------------------------------------------
// crp_bin_if
// Input channel: one complex bin per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crp_bin_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] real_part;
  logic signed [DATA_WIDTH-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

// ===== rtl/crp_polar_if.sv =====
// ----------------------------------------------------------------------------
// crp_polar_if
// Output channel: magnitude and phase of one bin per item, valid/ready.
// ----------------------------------------------------------------------------
interface crp_polar_if #(
  parameter int DATA_WIDTH  = 16,
  parameter int PHASE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [DATA_WIDTH-1:0]  magnitude;
  logic [PHASE_WIDTH-1:0] phase_turn;

  modport source (output valid, output magnitude, output phase_turn, input ready);
  modport sink   (input valid, input magnitude, input phase_turn, output ready);
endinterface

// ===== rtl/complex_rect_to_polar_top.sv =====
// ----------------------------------------------------------------------------
// complex_rect_to_polar_top
// Rectangular-to-polar converter for complex bins: magnitude and wrapped
// phase as a fraction of a turn.
// ----------------------------------------------------------------------------
// Usage:
//   bin   : input channel, one complex bin (real_part, imag_part) per item.
//   polar : output channel, magnitude and phase_turn, one item per bin, in order.
//   The 31-stage CORDIC chain sets the pipeline depth up to DATA_WIDTH 30;
//   above that the one-bit-per-stage square root does.
//   Throughput: one item per cycle; bin.ready stays high while the receiver
//   keeps up.
//   Reset (rst, synchronous) clears all valid bits; items in flight are
//   dropped and no output item is shown.
//   Stall: an output register and one skid entry hold finished items. While
//   the skid entry is occupied the whole pipeline holds and bin.ready is low;
//   no item is lost or repeated.
// ----------------------------------------------------------------------------
`include "complex_rect_to_polar_top_macros.svh"

module complex_rect_to_polar_top import crp_pkg::*; #(
  parameter int DATA_WIDTH  = 16,
  parameter int PHASE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  crp_bin_if.sink     bin,
  crp_polar_if.source polar
);

  localparam int MAG_LATENCY = DATA_WIDTH + 3;
  localparam int PIPE_LAT    = (MAG_LATENCY > PHASE_LATENCY) ? MAG_LATENCY : PHASE_LATENCY;

  logic                   adv;
  logic                   full;
  logic                   push;
  logic [PIPE_LAT-1:0]    vld;
  logic [DATA_WIDTH-1:0]  magnitude;
  logic [PHASE_WIDTH-1:0] phase_turn;

  assign adv       = !full;
  assign bin.ready = adv;
  assign push      = adv && vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], bin.valid};
    end
  end

  crp_mag #(
    .DATA_WIDTH (DATA_WIDTH),
    .LATENCY    (PIPE_LAT)
  ) u_mag (
    .clk       (clk),
    .en        (adv),
    .real_part (bin.real_part),
    .imag_part (bin.imag_part),
    .magnitude (magnitude)
  );

  crp_cordic #(
    .DATA_WIDTH  (DATA_WIDTH),
    .PHASE_WIDTH (PHASE_WIDTH),
    .LATENCY     (PIPE_LAT)
  ) u_cordic (
    .clk        (clk),
    .en         (adv),
    .real_part  (bin.real_part),
    .imag_part  (bin.imag_part),
    .phase_turn (phase_turn)
  );

  crp_skid #(
    .DATA_WIDTH  (DATA_WIDTH),
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .magnitude  (magnitude),
    .phase_turn (phase_turn),
    .full       (full),
    .polar      (polar)
  );

  `CRP_ASSERT_NEXT(a_hold_on_stall, clk, rst, !adv, $stable(vld), "pipeline moved while held")

endmodule

// ===== rtl/crp_mag.sv =====
// ----------------------------------------------------------------------------
// crp_mag
// Magnitude pipeline: squares, sum, one root bit per stage, round half up,
// then delay registers to match the phase pipeline.
// ----------------------------------------------------------------------------
module crp_mag import crp_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int LATENCY    = 19
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] real_part,
  input  logic signed [DATA_WIDTH-1:0] imag_part,
  output logic [DATA_WIDTH-1:0]        magnitude
);

  localparam int SW  = 2 * DATA_WIDTH;
  localparam int RW  = DATA_WIDTH + 3;
  localparam int PAD = LATENCY - DATA_WIDTH - 3;

  logic signed [SW-1:0] re_w;
  logic signed [SW-1:0] im_w;
  logic [SW-1:0]        sq_re;
  logic [SW-1:0]        sq_im;

  logic [SW-1:0]         s   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] q   [DATA_WIDTH+1];
  logic [RW-1:0]         rem [DATA_WIDTH+1];

  logic [DATA_WIDTH-1:0] mag_dly [PAD+1];

  assign re_w = SW'(real_part);
  assign im_w = SW'(imag_part);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_re  <= $unsigned(re_w * re_w);
      sq_im  <= $unsigned(im_w * im_w);
      s[0]   <= sq_re + sq_im;
      q[0]   <= '0;
      rem[0] <= '0;
    end
  end

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_root
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    assign rem_sh = {rem[k][RW-3:0], s[k][2*(DATA_WIDTH-1-k)+1 -: 2]};
    assign trial  = RW'({q[k], 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        s[k+1] <= s[k];
        if (rem_sh >= trial) begin
          rem[k+1] <= rem_sh - trial;
          q[k+1]   <= {q[k][DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem[k+1] <= rem_sh;
          q[k+1]   <= {q[k][DATA_WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_dly[0] <= (rem[DATA_WIDTH] > RW'(q[DATA_WIDTH])) ?
                    q[DATA_WIDTH] + 1'b1 : q[DATA_WIDTH];
    end
  end

  for (genvar d = 0; d < PAD; d++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        mag_dly[d+1] <= mag_dly[d];
      end
    end
  end

  assign magnitude = mag_dly[PAD];

endmodule

// ===== rtl/crp_cordic.sv =====
// ----------------------------------------------------------------------------
// crp_cordic
// Phase pipeline: axis and half-plane sort, one CORDIC vectoring step per
// stage, rounding to the output phase width, delay registers to match.
// ----------------------------------------------------------------------------
module crp_cordic import crp_pkg::*; #(
  parameter int DATA_WIDTH  = 16,
  parameter int PHASE_WIDTH = 16,
  parameter int LATENCY     = 33
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [DATA_WIDTH-1:0] real_part,
  input  logic signed [DATA_WIDTH-1:0] imag_part,
  output logic [PHASE_WIDTH-1:0]       phase_turn
);

  localparam int XW  = DATA_WIDTH + PRESCALE + GUARD_BITS;
  localparam int SH  = ANGLE_WIDTH - PHASE_WIDTH;
  localparam int PAD = LATENCY - PHASE_LATENCY;
  localparam logic [ANGLE_WIDTH-1:0] ROUND_HALF = ANGLE_WIDTH'((64'd1 << SH) >> 1);

  logic signed [XW-1:0] re_ext;
  logic signed [XW-1:0] im_ext;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic [ANGLE_WIDTH-1:0] z_next;
  logic                   axis_next;
  logic [ANGLE_WIDTH-1:0] axis_ang_next;

  logic signed [XW-1:0]   x        [CORDIC_STEPS+1];
  logic signed [XW-1:0]   y        [CORDIC_STEPS+1];
  logic [ANGLE_WIDTH-1:0] z        [CORDIC_STEPS+1];
  logic                   axis     [CORDIC_STEPS+1];
  logic [ANGLE_WIDTH-1:0] axis_ang [CORDIC_STEPS+1];

  logic [ANGLE_WIDTH-1:0] ang;
  logic [ANGLE_WIDTH-1:0] ang_rnd;
  logic [PHASE_WIDTH-1:0] ph_dly [PAD+1];

  assign re_ext = XW'(real_part);
  assign im_ext = XW'(imag_part);

  always_comb begin
    if (real_part < 0) begin
      x_next = (-re_ext) <<< PRESCALE;
      y_next = (-im_ext) <<< PRESCALE;
      z_next = HALF_TURN;
    end else begin
      x_next = re_ext <<< PRESCALE;
      y_next = im_ext <<< PRESCALE;
      z_next = ZERO_TURN;
    end
    axis_next = (real_part == 0) || (imag_part == 0);
    if (imag_part == 0) begin
      axis_ang_next = (real_part < 0) ? HALF_TURN : ZERO_TURN;
    end else begin
      axis_ang_next = (imag_part > 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]        <= x_next;
      y[0]        <= y_next;
      z[0]        <= z_next;
      axis[0]     <= axis_next;
      axis_ang[0] <= axis_ang_next;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        axis[i+1]     <= axis[i];
        axis_ang[i+1] <= axis_ang[i];
        if (y[i] > 0) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + ATAN_TURN[i];
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - ATAN_TURN[i];
        end
      end
    end
  end

  assign ang     = axis[CORDIC_STEPS] ? axis_ang[CORDIC_STEPS] : z[CORDIC_STEPS];
  assign ang_rnd = ang + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_dly[0] <= ang_rnd[ANGLE_WIDTH-1:SH];
    end
  end

  for (genvar d = 0; d < PAD; d++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        ph_dly[d+1] <= ph_dly[d];
      end
    end
  end

  assign phase_turn = ph_dly[PAD];

endmodule

// ===== rtl/crp_skid.sv =====
// ----------------------------------------------------------------------------
// crp_skid
// Output register plus one skid entry between the pipeline and the output
// channel; full stops the pipeline.
// ----------------------------------------------------------------------------
`include "complex_rect_to_polar_top_macros.svh"

module crp_skid import crp_pkg::*; #(
  parameter int DATA_WIDTH  = 16,
  parameter int PHASE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [DATA_WIDTH-1:0]  magnitude,
  input  logic [PHASE_WIDTH-1:0] phase_turn,
  output logic                   full,
  crp_polar_if.source            polar
);

  logic                   out_valid;
  logic [DATA_WIDTH-1:0]  out_mag;
  logic [PHASE_WIDTH-1:0] out_phase;
  logic                   skid_valid;
  logic [DATA_WIDTH-1:0]  skid_mag;
  logic [PHASE_WIDTH-1:0] skid_phase;
  logic                   take;

  assign take = out_valid && polar.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_mag   <= skid_mag;
        out_phase <= skid_phase;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_mag   <= magnitude;
        out_phase <= phase_turn;
      end else begin
        skid_mag   <= magnitude;
        skid_phase <= phase_turn;
      end
    end
  end

  assign full             = skid_valid;
  assign polar.valid      = out_valid;
  assign polar.magnitude  = out_mag;
  assign polar.phase_turn = out_phase;

  `CRP_ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid item without output item")
  `CRP_ASSERT_IMPLIES(a_no_push_full, clk, rst, push, !skid_valid, "item pushed into full skid")
  `CRP_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && polar.ready, !skid_valid && out_valid, "skid item not moved to output")

endmodule
